// ----- design/ipc_pkg.sv -----
`default_nettype none

package ipc_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_cnt DEPTH_CNT = CNT_W'(STACK_DEPTH);

    localparam logic [7:0] CH_POW    = 8'h5E;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_ADD    = 8'h2B;
    localparam logic [7:0] CH_SUB    = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;

    typedef enum logic [2:0] {
        OP_POW    = 3'd0,
        OP_MUL    = 3'd1,
        OP_DIV    = 3'd2,
        OP_ADD    = 3'd3,
        OP_SUB    = 3'd4,
        OP_LPAREN = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        K_OTHER,
        K_LETTER,
        K_ARITH,
        K_OPEN,
        K_CLOSE
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_OP,
        ST_POP_CL,
        ST_DRAIN,
        ST_END
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
        t_op  code;
    } t_stk_ctl;

    function automatic logic [2:0] op_rank(input t_op op);
        logic [2:0] r;
        case (op)
            OP_POW:         r = 3'd4;
            OP_MUL, OP_DIV: r = 3'd3;
            OP_ADD, OP_SUB: r = 3'd2;
            default:        r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] op_char(input t_op op);
        logic [7:0] c;
        case (op)
            OP_POW:  c = CH_POW;
            OP_MUL:  c = CH_MUL;
            OP_DIV:  c = CH_DIV;
            OP_ADD:  c = CH_ADD;
            OP_SUB:  c = CH_SUB;
            default: c = CH_LPAREN;
        endcase
        return c;
    endfunction

    function automatic t_op sym_to_op(input logic [7:0] sym);
        t_op op;
        case (sym)
            CH_POW:  op = OP_POW;
            CH_MUL:  op = OP_MUL;
            CH_DIV:  op = OP_DIV;
            CH_ADD:  op = OP_ADD;
            CH_SUB:  op = OP_SUB;
            default: op = OP_LPAREN;
        endcase
        return op;
    endfunction

    function automatic t_kind sym_kind(input logic [7:0] sym);
        t_kind k;
        if (sym >= CH_LOW_A && sym <= CH_LOW_Z) begin
            k = K_LETTER;
        end else begin
            case (sym)
                CH_POW, CH_MUL, CH_DIV, CH_ADD, CH_SUB: k = K_ARITH;
                CH_LPAREN: k = K_OPEN;
                CH_RPAREN: k = K_CLOSE;
                default:   k = K_OTHER;
            endcase
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- design/ipc_in_if.sv -----
`default_nettype none

interface ipc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       expr_end;

    modport source (output valid, output symbol, output expr_end, input ready);
    modport sink   (input valid, input symbol, input expr_end, output ready);
endinterface

`default_nettype wire

// ----- design/ipc_out_if.sv -----
`default_nettype none

interface ipc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_symbol;
    logic       out_valid;
    logic       run_last;
    logic       expr_done;
    logic       error_flag;

    modport source (output valid, output out_symbol, output out_valid, output run_last,
                    output expr_done, output error_flag, input ready);
    modport sink   (input valid, input out_symbol, input out_valid, input run_last,
                    input expr_done, input error_flag, output ready);
endinterface

`default_nettype wire

// ----- design/ipc_cell.sv -----
`default_nettype none

module ipc_cell (
    input  logic              i_clk,
    input  ipc_pkg::t_stk_ctl i_ctl,
    input  ipc_pkg::t_op      i_up,
    input  ipc_pkg::t_op      i_down,
    output ipc_pkg::t_op      o_code
);
    import ipc_pkg::*;

    t_op r_code;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_code <= i_up;
        end else if (i_ctl.pop) begin
            r_code <= i_down;
        end
    end

    assign o_code = r_code;

endmodule

`default_nettype wire

// ----- design/ipc_stack.sv -----
`default_nettype none

module ipc_stack (
    input  logic              i_clk,
    input  ipc_pkg::t_stk_ctl i_ctl,
    output ipc_pkg::t_op      o_top
);
    import ipc_pkg::*;

    t_op w_code [STACK_DEPTH];

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            t_op w_up;
            t_op w_down;

            if (g == 0) begin : g_head
                assign w_up = i_ctl.code;
            end else begin : g_body
                assign w_up = w_code[g-1];
            end

            if (g == STACK_DEPTH - 1) begin : g_tail
                assign w_down = w_code[g];
            end else begin : g_inner
                assign w_down = w_code[g+1];
            end

            ipc_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (i_ctl),
                .i_up   (w_up),
                .i_down (w_down),
                .o_code (w_code[g])
            );
        end
    endgenerate

    assign o_top = w_code[0];

endmodule

`default_nettype wire

// ----- design/infix_to_postfix_converter.sv -----
// Infix to postfix converter (shunting yard) with a shift-chain operator stack.
// Input channel i_in: one ASCII character per transaction (symbol), expr_end
// marks the last character of an expression. Output channel o_out: one postfix
// character per transaction, with run_last on the final one caused by an input
// transaction, expr_done on the final one of the expression, and a sticky
// error_flag (unmatched close paren or stack overflow). An expression end that
// produces nothing gives one empty marker with out_valid low.
// The stack top sits in the first cell of the chain; push and pop shift the
// whole chain by one cell at once, so operators are popped one at a time.
// States per input transaction: letters, ignored bytes and '(' go from IDLE
// to END; an operator pops through POP_OP and ')' through POP_CL first;
// with expr_end, DRAIN then emits every stack entry before END.
// Each result is held one step back so run_last is known when it is sent.
// Reset empties the stack and hold, clears the error flag and output valid.
// When the receiver stalls, the output register holds its transaction and the
// converter waits; no new character is accepted until the current one is done.
`default_nettype none

module infix_to_postfix_converter (
    input logic        i_clk,
    input logic        i_rst_n,
    ipc_in_if.sink     i_in,
    ipc_out_if.source  o_out
);
    import ipc_pkg::*;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_last, n_last;
    logic   r_err, n_err;
    t_cnt   r_cnt, n_cnt;
    t_cnt   r_pcnt, n_pcnt;
    logic   r_hold_v, n_hold_v;
    logic [7:0] r_hold_ch, n_hold_ch;
    logic   r_ov, n_ov;
    logic [7:0] r_osym, n_osym;
    logic   r_oval, n_oval;
    logic   r_orl, n_orl;
    logic   r_oed, n_oed;
    logic   r_oerr, n_oerr;

    t_stk_ctl w_ctl;
    t_op      w_top;
    logic     w_out_free;
    logic     w_emit_ok;
    logic     w_emit;
    logic [7:0] w_emit_ch;
    logic     w_fin;
    t_kind    w_kind;
    t_op      w_in_op;
    t_state   w_after;

    ipc_stack u_stack (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_top  (w_top)
    );

    assign w_out_free = !r_ov || o_out.ready;
    assign w_emit_ok  = !r_hold_v || w_out_free;
    assign w_kind     = sym_kind(i_in.symbol);
    assign w_in_op    = sym_to_op(i_in.symbol);
    assign w_after    = r_last ? ST_DRAIN : ST_END;

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_ov;
    assign o_out.out_symbol = r_osym;
    assign o_out.out_valid  = r_oval;
    assign o_out.run_last   = r_orl;
    assign o_out.expr_done  = r_oed;
    assign o_out.error_flag = r_oerr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_err    <= 1'b0;
            r_cnt    <= '0;
            r_pcnt   <= '0;
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_err    <= n_err;
            r_cnt    <= n_cnt;
            r_pcnt   <= n_pcnt;
            r_hold_v <= n_hold_v;
            r_ov     <= n_ov;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_hold_ch <= n_hold_ch;
        r_osym    <= n_osym;
        r_oval    <= n_oval;
        r_orl     <= n_orl;
        r_oed     <= n_oed;
        r_oerr    <= n_oerr;
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_last    = r_last;
        n_err     = r_err;
        n_cnt     = r_cnt;
        n_pcnt    = r_pcnt;
        n_hold_v  = r_hold_v;
        n_hold_ch = r_hold_ch;
        n_ov      = r_ov && !o_out.ready;
        n_osym    = r_osym;
        n_oval    = r_oval;
        n_orl     = r_orl;
        n_oed     = r_oed;
        n_oerr    = r_oerr;
        w_ctl     = '{push: 1'b0, pop: 1'b0, code: r_op};
        w_emit    = 1'b0;
        w_emit_ch = op_char(w_top);
        w_fin     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_last = i_in.expr_end;
                    n_op   = w_in_op;
                    n_state = i_in.expr_end ? ST_DRAIN : ST_END;
                    case (w_kind)
                        K_LETTER: begin
                            w_emit    = 1'b1;
                            w_emit_ch = i_in.symbol;
                        end
                        K_ARITH: begin
                            n_state = ST_POP_OP;
                            if (r_cnt == DEPTH_CNT && op_rank(w_top) < op_rank(w_in_op)) begin
                                n_err = 1'b1;
                            end
                        end
                        K_OPEN: begin
                            if (r_cnt != DEPTH_CNT) begin
                                w_ctl.push = 1'b1;
                                w_ctl.code = OP_LPAREN;
                                n_cnt      = r_cnt + t_cnt'(1);
                                n_pcnt     = r_pcnt + t_cnt'(1);
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        K_CLOSE: begin
                            n_state = ST_POP_CL;
                            if (r_pcnt == '0) begin
                                n_err = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_POP_OP: begin
                if (r_cnt != '0 && op_rank(w_top) >= op_rank(r_op)) begin
                    if (w_emit_ok) begin
                        w_emit    = 1'b1;
                        w_ctl.pop = 1'b1;
                        n_cnt     = r_cnt - t_cnt'(1);
                    end
                end else begin
                    if (r_cnt != DEPTH_CNT) begin
                        w_ctl.push = 1'b1;
                        n_cnt      = r_cnt + t_cnt'(1);
                    end
                    n_state = w_after;
                end
            end
            ST_POP_CL: begin
                if (r_cnt != '0 && w_top != OP_LPAREN) begin
                    if (w_emit_ok) begin
                        w_emit    = 1'b1;
                        w_ctl.pop = 1'b1;
                        n_cnt     = r_cnt - t_cnt'(1);
                    end
                end else begin
                    if (r_cnt != '0) begin
                        w_ctl.pop = 1'b1;
                        n_cnt     = r_cnt - t_cnt'(1);
                        n_pcnt    = r_pcnt - t_cnt'(1);
                    end
                    n_state = w_after;
                end
            end
            ST_DRAIN: begin
                if (r_cnt != '0) begin
                    if (w_emit_ok) begin
                        w_emit    = 1'b1;
                        w_ctl.pop = 1'b1;
                        n_cnt     = r_cnt - t_cnt'(1);
                        if (w_top == OP_LPAREN) begin
                            n_pcnt = r_pcnt - t_cnt'(1);
                        end
                    end
                end else begin
                    n_state = ST_END;
                end
            end
            ST_END: begin
                if (!(r_hold_v || r_last) || w_out_free) begin
                    w_fin   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // held character goes out once the next one is known
        if (w_emit) begin
            if (r_hold_v) begin
                n_ov   = 1'b1;
                n_osym = r_hold_ch;
                n_oval = 1'b1;
                n_orl  = 1'b0;
                n_oed  = 1'b0;
                n_oerr = n_err;
            end
            n_hold_v  = 1'b1;
            n_hold_ch = w_emit_ch;
        end

        if (w_fin) begin
            if (r_hold_v) begin
                n_ov     = 1'b1;
                n_osym   = r_hold_ch;
                n_oval   = 1'b1;
                n_orl    = 1'b1;
                n_oed    = r_last;
                n_oerr   = r_err;
                n_hold_v = 1'b0;
            end else if (r_last) begin
                n_ov   = 1'b1;
                n_osym = '0;
                n_oval = 1'b0;
                n_orl  = 1'b1;
                n_oed  = 1'b1;
                n_oerr = r_err;
            end
        end
    end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import ipc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 200;
    localparam int SETTLE         = 16;
    localparam int MAX_OPENS      = 4;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       out_valid;
        logic       run_last;
        logic       expr_done;
        logic       error_flag;
    } t_postfix_char;

    logic i_clk;
    logic i_rst_n;

    ipc_in_if  in_if ();
    ipc_out_if out_if ();

    infix_to_postfix_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // own copy of the operator stack
    t_op           op_stack [STACK_DEPTH];
    int unsigned   stack_fill = 0;
    logic          err_sticky = 1'b0;
    t_postfix_char postfix_q [$];

    int src_idle_pct  = 26;
    int sink_idle_pct = 56;
    int hold_orders   = 0;
    int hold_taken    = 0;
    int hold_left     = 0;
    int n_sent        = 0;
    int n_recv        = 0;
    int n_errors      = 0;
    int quiet_cycles  = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int precedence_of(input t_op op);
        case (op)
            OP_POW:         return 4;
            OP_MUL, OP_DIV: return 3;
            OP_ADD, OP_SUB: return 2;
            default:        return -1;
        endcase
    endfunction

    function automatic logic [7:0] op_symbol(input t_op op);
        case (op)
            OP_POW:  return CH_POW;
            OP_MUL:  return CH_MUL;
            OP_DIV:  return CH_DIV;
            OP_ADD:  return CH_ADD;
            OP_SUB:  return CH_SUB;
            default: return CH_LPAREN;
        endcase
    endfunction

    function automatic void push_op(input t_op op);
        if (stack_fill >= STACK_DEPTH) begin
            err_sticky = 1'b1;
        end else begin
            op_stack[stack_fill] = op;
            stack_fill++;
        end
    endfunction

    function automatic logic [7:0] random_letter();
        return CH_LOW_A + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 4))
            0:       return CH_POW;
            1:       return CH_MUL;
            2:       return CH_DIV;
            3:       return CH_ADD;
            default: return CH_SUB;
        endcase
    endfunction

    // shunting-yard step: queue the postfix characters this symbol produces
    task automatic convert_symbol(input logic [7:0] sym, input logic last);
        logic [7:0] emitted [$];
        t_op        op;
        bit         is_arith;
        int         p;
        is_arith = 1'b1;
        case (sym)
            CH_POW:  op = OP_POW;
            CH_MUL:  op = OP_MUL;
            CH_DIV:  op = OP_DIV;
            CH_ADD:  op = OP_ADD;
            CH_SUB:  op = OP_SUB;
            default: begin
                op = OP_LPAREN;
                is_arith = 1'b0;
            end
        endcase
        if (sym >= CH_LOW_A && sym <= CH_LOW_Z) begin
            emitted.push_back(sym);
        end else if (is_arith) begin
            p = precedence_of(op);
            while (stack_fill > 0 && precedence_of(op_stack[stack_fill-1]) >= p) begin
                emitted.push_back(op_symbol(op_stack[stack_fill-1]));
                stack_fill--;
            end
            push_op(op);
        end else if (sym == CH_LPAREN) begin
            push_op(OP_LPAREN);
        end else if (sym == CH_RPAREN) begin
            while (stack_fill > 0 && op_stack[stack_fill-1] != OP_LPAREN) begin
                emitted.push_back(op_symbol(op_stack[stack_fill-1]));
                stack_fill--;
            end
            if (stack_fill > 0) begin
                stack_fill--;
            end else begin
                err_sticky = 1'b1;
            end
        end
        if (last) begin
            while (stack_fill > 0) begin
                emitted.push_back(op_symbol(op_stack[stack_fill-1]));
                stack_fill--;
            end
        end
        if (last && emitted.size() == 0) begin
            postfix_q.push_back('{8'h00, 1'b0, 1'b1, 1'b1, err_sticky});
        end else begin
            foreach (emitted[k]) begin
                postfix_q.push_back('{emitted[k], 1'b1, k == emitted.size() - 1,
                                      last && (k == emitted.size() - 1), err_sticky});
            end
        end
    endtask

    task automatic send_char(input logic [7:0] sym, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.symbol   <= sym;
        in_if.expr_end <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        n_sent++;
        convert_symbol(sym, last);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (postfix_q.size() != 0) @(posedge i_clk);
    endtask

    // well-formed expression, optionally mutated into a broken one
    task automatic send_random_expr(input bit broken);
        logic [7:0] expr [$];
        int         terms;
        int         opens;
        int         n;
        int         pos;
        logic       last_flag;
        terms = $urandom_range(1, 6);
        opens = 0;
        for (int k = 0; k < terms; k++) begin
            n = $urandom_range(0, 2);
            while (n > 0 && opens < MAX_OPENS) begin
                expr.push_back(CH_LPAREN);
                opens++;
                n--;
            end
            expr.push_back(random_letter());
            n = $urandom_range(0, opens);
            repeat (n) expr.push_back(CH_RPAREN);
            opens -= n;
            if (k < terms - 1) expr.push_back(random_operator());
        end
        repeat (opens) expr.push_back(CH_RPAREN);
        last_flag = 1'b1;
        if (broken) begin
            pos = $urandom_range(0, expr.size() - 1);
            case ($urandom_range(0, 2))
                0:       expr.insert(pos, CH_RPAREN);
                1:       expr.delete(pos);
                default: expr.insert(pos, 8'($urandom_range(0, 255)));
            endcase
            last_flag = 1'($urandom_range(0, 1));
        end
        foreach (expr[i]) begin
            send_char(expr[i], last_flag && (i == expr.size() - 1));
        end
    endtask

    task automatic test_letters_and_ignored();
        send_char(CH_LOW_A, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h60, 1'b0);
        send_char(8'h7B, 1'b0);
        send_char(CH_LOW_Z, 1'b1);
        // end on an ignored byte with an empty stack gives the empty marker
        send_char(8'h20, 1'b1);
    endtask

    task automatic test_precedence();
        send_text("a+b*c^d-e/f");
    endtask

    task automatic test_parens();
        send_text("(a-b)^c");
        // lone open paren: quiet, then drained as a character
        send_char(CH_LPAREN, 1'b1);
    endtask

    task automatic test_random_exprs(input int count);
        repeat (count) send_random_expr(1'b0);
    endtask

    task automatic test_output_hold();
        hold_orders <= hold_orders + 1;
        send_char(random_letter(), 1'b0);
        repeat (11) begin
            send_char(CH_MUL, 1'b0);
            send_char(random_letter(), 1'b0);
        end
        send_char(CH_ADD, 1'b0);
        send_char(random_letter(), 1'b1);
        drain_results();
    endtask

    task automatic test_stack_overflow();
        repeat (STACK_DEPTH) send_char(CH_LPAREN, 1'b0);
        send_char(CH_ADD, 1'b0);
        send_char(random_letter(), 1'b1);
        drain_results();
    endtask

    task automatic test_unmatched_close();
        send_text("a+b)");
        send_char(CH_RPAREN, 1'b1);
    endtask

    task automatic test_noise(input int broken_count, input int noise_count);
        repeat (broken_count) send_random_expr(1'b1);
        repeat (noise_count) begin
            if ($urandom_range(0, 1)) begin
                send_char(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
            end else begin
                case ($urandom_range(0, 3))
                    0:       send_char(CH_LPAREN, $urandom_range(0, 5) == 0);
                    1:       send_char(CH_RPAREN, $urandom_range(0, 5) == 0);
                    2:       send_char(random_operator(), $urandom_range(0, 5) == 0);
                    default: send_char(random_letter(), $urandom_range(0, 5) == 0);
                endcase
            end
        end
        send_char(8'h20, 1'b1);
    endtask

    // receiver: random stalls, or a long hold when one is ordered
    always @(posedge i_clk) begin
        if (hold_orders != hold_taken) begin
            hold_taken   <= hold_orders;
            hold_left    <= LONG_HOLD;
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_postfix_char want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            n_recv++;
            if (postfix_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %h/%b",
                         $time, out_if.out_symbol, out_if.out_valid);
                n_errors++;
            end else begin
                want = postfix_q.pop_front();
                check_field("out_symbol", want.out_symbol, out_if.out_symbol);
                check_field("out_valid", want.out_valid, out_if.out_valid);
                check_field("run_last", want.run_last, out_if.run_last);
                check_field("expr_done", want.expr_done, out_if.expr_done);
                check_field("error_flag", want.error_flag, out_if.error_flag);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("infix_to_postfix_converter test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.symbol   = 8'h00;
        in_if.expr_end = 1'b0;
        out_if.ready   = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_letters_and_ignored();
        test_precedence();
        test_parens();
        test_random_exprs(3);

        src_idle_pct = 56;
        sink_idle_pct <= 26;
        test_random_exprs(4);
        test_output_hold();

        src_idle_pct = 0;
        sink_idle_pct <= 0;
        test_random_exprs(3);
        drain_results();

        // from here on the error flag is set for good
        test_stack_overflow();
        test_unmatched_close();
        src_idle_pct = 26;
        sink_idle_pct <= 56;
        test_noise(2, 20);

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        $display("sent %0d characters, checked %0d postfix transactions", n_sent, n_recv);
        $display("covered precedence, parens, empty end, long output hold, overflow, "
                 , "unmatched close and noise");
        if (n_errors == 0 && postfix_q.size() == 0) begin
            $display("infix_to_postfix_converter test passed");
        end else begin
            $display("infix_to_postfix_converter test failed");
        end
        $finish;
    end

endmodule
